// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the wavelength sampler.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== hdl/cws_pkg.sv =====
// Package of the CIE wavelength sampler: widths, codes, transfer structs and tables.
// Used by cws_curve and cie_wavelength_sampler; depends on nothing.
package cws_pkg;

	localparam int MAX_BANDS  = 64;
	localparam int BAND_W     = $clog2(MAX_BANDS);
	localparam int CNT_W      = BAND_W + 1;
	localparam int NUM_CURVES = 3;
	localparam int MEM_DEPTH  = NUM_CURVES * MAX_BANDS;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);

	localparam int WL_W  = 26;
	localparam int BW_W  = 25;
	localparam int BC_W  = 7;
	localparam int CDF_W = 33;
	localparam int RND_W = 32;
	localparam int LAM_W = 33;
	localparam int F_W   = 34;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam logic       OP_LOAD   = 1'b0;
	localparam logic       OP_SAMPLE = 1'b1;
	localparam logic [1:0] CURVE_BAD = 2'd3;
	localparam logic       STAT_OK   = 1'b0;
	localparam logic       STAT_NOROOT = 1'b1;

	localparam logic [WL_W-1:0] START_RST = 26'd24903680;
	localparam logic [BW_W-1:0] WIDTH_RST = 25'd409600;
	localparam logic [BC_W-1:0] COUNT_RST = 7'd64;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	// Above 33*ln2 the shift count exceeds 32 and the exponential is zero.
	localparam logic [38:0] X_LIM   = 39'd98242467576;
	localparam logic [64:0] EPS_Q60 = 65'd1152921504607;
	localparam logic [WL_W-1:0] WL_MAX = 26'h3FF_FFFF;

	typedef struct packed {
		logic              opcode;
		logic [1:0]        curve_select;
		logic [5:0]        entry_index;
		logic [CDF_W-1:0]  entry_value;
		logic [RND_W-1:0]  rand_band;
		logic [RND_W-1:0]  rand_within;
	} cmd_t;

	typedef struct packed {
		logic [WL_W-1:0] wavelength;
		logic [5:0]      band_index;
		logic            status;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [1:0]       curve;
		logic [LAM_W-1:0] lam;
	} crv_req_t;

	typedef struct packed {
		logic           done;
		logic [F_W-1:0] f;
	} crv_rsp_t;

	typedef struct packed {
		logic [25:0] mu;
		logic [16:0] s_below;
		logic [16:0] s_above;
		logic [16:0] w;
		logic        neg;
	} lobe_t;

	// Piecewise-Gaussian fit: centers Q.16, slopes Q.20, weights Q.16.
	function automatic lobe_t lobe_get(input logic [1:0] curve, input logic [1:0] idx);
		lobe_t lb;
		unique case ({curve, idx})
			4'b00_00: lb = '{26'd28966912, 17'd65431, 17'd39217, 17'd23724, 1'b0};
			4'b00_01: lb = '{26'd39308493, 17'd27682, 17'd33869, 17'd69206, 1'b0};
			4'b00_10: lb = '{26'd32840090, 17'd51380, 17'd40056, 17'd4260,  1'b1};
			4'b01_00: lb = '{26'd37276877, 17'd22335, 17'd25900, 17'd53805, 1'b0};
			4'b01_01: lb = '{26'd34793062, 17'd64278, 17'd33764, 17'd18743, 1'b0};
			4'b10_00: lb = '{26'd28639232, 17'd88605, 17'd29150, 17'd79757, 1'b0};
			4'b10_01: lb = '{26'd30081024, 17'd40370, 17'd76022, 17'd44630, 1'b0};
			default:  lb = '0;
		endcase
		return lb;
	endfunction

	// floor(2^36 / n) for the Horner divisors 1 to 9.
	function automatic logic [36:0] recip36(input logic [3:0] n);
		logic [36:0] m;
		unique case (n)
			4'd1:    m = 37'd68719476736;
			4'd2:    m = 37'd34359738368;
			4'd3:    m = 37'd22906492245;
			4'd4:    m = 37'd17179869184;
			4'd5:    m = 37'd13743895347;
			4'd6:    m = 37'd11453246122;
			4'd7:    m = 37'd9817068105;
			4'd8:    m = 37'd8589934592;
			4'd9:    m = 37'd7635497415;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/cie_wavelength_sampler.sv =====
// Top level of the CIE 1931 wavelength sampler: CDF memory, band scan and band solve.
// Depends on cws_pkg, cws_curve and assert_macros.svh.
//
//  channel   signals                          transfer
//  command   start, busy, cmd                 start high while busy low
//  result    done, result                     done high for one cycle
//  config    cfg_we, cfg_addr, cfg_wdata      cfg_we high
//
// A load is written without raising busy. A sample keeps busy high at most through a scan
// of the n bands in use from the single memory read port, the edge state, a curve
// evaluation in the serial curve unit at each band edge, the discriminant states, 32 root
// steps, a 30-step divider and the root, scale and final states; done is raised as busy
// falls. Reset clears control state and sets the configuration defaults; the CDF memory
// is undefined until loaded. The receiver cannot stall.
module cie_wavelength_sampler import cws_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cmd_t            cmd,
	output logic            busy,
	output logic            done,
	output res_t            result,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_addr,
	input  logic [WL_W-1:0] cfg_wdata
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_SCAN  = 16'h0002,
		S_EDGE  = 16'h0004,
		S_CMIN  = 16'h0008,
		S_CMAX  = 16'h0010,
		S_SQ0   = 16'h0020,
		S_SQ1   = 16'h0040,
		S_DP0   = 16'h0080,
		S_DP1   = 16'h0100,
		S_DP2   = 16'h0200,
		S_DSC   = 16'h0400,
		S_SQRT  = 16'h0800,
		S_ROOT  = 16'h1000,
		S_DIV   = 16'h2000,
		S_SCALE = 16'h4000,
		S_FIN   = 16'h8000
	} state_t;

	localparam int NUM_W = F_W + 2;
	localparam int DR_W  = F_W + 3;

	state_t state_q;
	logic [WL_W-1:0] start_q;
	logic [BW_W-1:0] bw_q;
	logic [BC_W-1:0] bc_q;

	logic [CDF_W-1:0] mem [0:MEM_DEPTH-1];
	logic [CDF_W-1:0] rd_data_q;

	logic [1:0]        curve_q;
	logic [RND_W-1:0]  r0_q, r1_q;
	logic [CNT_W-1:0]  n_q, rd_idx_q;
	logic              cmp_valid_s1;
	logic [BAND_W-1:0] cmp_idx_s1, ib_q;
	logic [LAM_W-1:0]  lmin_q;
	logic signed [F_W-1:0] fmin_q;
	logic signed [F_W:0]   a_q;
	logic              flat_q;
	logic [63:0]       s0_q, s1_q, dif_q, hi_q, lo_q;
	logic              dneg_q;
	logic [63:0]       sx_q, sres_q, sbit_q;
	logic [DR_W-1:0]   drem_q, dma_q;
	logic [29:0]       dq_q;
	logic [4:0]        dcnt_q;
	logic [BW_W-1:0]   off_q;
	logic              done_q;
	res_t              res_q;

	crv_req_t crv_req;
	crv_rsp_t crv_rsp;

	logic              accept;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [CNT_W-1:0]  n_eff;
	logic [BAND_W-1:0] last_idx;
	logic [BW_W+BAND_W-1:0] bwib;
	logic [LAM_W-1:0]  lmin_c, lmax_c, lam_c;
	logic signed [F_W-1:0] fnew_c;
	logic signed [F_W:0]   a_c;
	logic [F_W-1:0]    mf0, mf1;
	logic [63:0]       delta_c;
	logic signed [64:0] dsc_c;
	logic [64:0]       dmag_c;
	logic [NUM_W-1:0]  fe_c, sqe_c, n1_c, n2_c, ma_c;
	logic              ok1_c, ok2_c;
	logic [DR_W-1:0]   dsh_c;
	logic [56:0]       pflat_c;
	logic [54:0]       pv_c;
	logic [LAM_W-1:0]  lam_fin;

	// Magnitude of a two's complement number held as plain bits.
	function automatic logic [NUM_W-1:0] mag_num(input logic [NUM_W-1:0] v);
		return v[NUM_W-1] ? (~v + 1'b1) : v;
	endfunction

	// True when num/a lies in [0, 1).
	function automatic logic root_ok(input logic [NUM_W-1:0] num, input logic [NUM_W-1:0] a);
		logic bad_sign;
		bad_sign = (|num) && ((!num[NUM_W-1]) != (!a[NUM_W-1]));
		return !bad_sign && (mag_num(num) < mag_num(a));
	endfunction

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RST;
			bw_q    <= WIDTH_RST;
			bc_q    <= COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START: start_q <= cfg_wdata;
				REG_WIDTH: bw_q    <= cfg_wdata[BW_W-1:0];
				REG_COUNT: bc_q    <= cfg_wdata[BC_W-1:0];
				default: ;
			endcase
		end
	end

	// CDF memory: loads are taken only while idle, so reads never race a write.
	always_comb begin
		mem_we  = accept && (cmd.opcode == OP_LOAD) && (cmd.curve_select != CURVE_BAD) &&
			({{(32-6){1'b0}}, cmd.entry_index} < 32'(MAX_BANDS));
		wr_addr = ADDR_W'(cmd.curve_select) * ADDR_W'(MAX_BANDS) +
			ADDR_W'(cmd.entry_index);
		mem_re  = (state_q == S_SCAN) && (rd_idx_q < n_q);
		rd_addr = ADDR_W'(curve_q) * ADDR_W'(MAX_BANDS) + ADDR_W'(rd_idx_q[BAND_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= cmd.entry_value;
		if (mem_re) rd_data_q <= mem[rd_addr];
	end

	// Band edges, discriminant, root selection and divider step.
	always_comb begin
		if (bc_q == '0) n_eff = CNT_W'(1);
		else if ({{(32-BC_W){1'b0}}, bc_q} > 32'(MAX_BANDS)) n_eff = CNT_W'(MAX_BANDS);
		else n_eff = CNT_W'(bc_q);
		last_idx = BAND_W'(n_q - CNT_W'(1));
		bwib     = bw_q * ib_q;
		lmin_c   = LAM_W'(start_q) + LAM_W'(bwib);
		lmax_c   = lmin_q + LAM_W'(bw_q);
		lam_c    = (state_q == S_EDGE) ? lmin_c : lmax_c;
		fnew_c   = $signed(crv_rsp.f);
		a_c      = $signed({fnew_c[F_W-1], fnew_c}) - $signed({fmin_q[F_W-1], fmin_q});
		mf0      = fmin_q[F_W-1] ? (~fmin_q + 1'b1) : fmin_q;
		mf1      = fnew_c[F_W-1] ? (~fnew_c + 1'b1) : fnew_c;
		delta_c  = hi_q + {32'b0, lo_q[63:32]};
		dsc_c    = dneg_q ? ($signed({1'b0, s0_q}) - $signed({1'b0, delta_c}))
			: ($signed({1'b0, s0_q}) + $signed({1'b0, delta_c}));
		dmag_c   = 65'd0 - dsc_c;
		fe_c     = {{(NUM_W-F_W){fmin_q[F_W-1]}}, fmin_q};
		sqe_c    = {{(NUM_W-32){1'b0}}, sres_q[31:0]};
		n1_c     = {NUM_W{1'b0}} - fe_c - sqe_c;
		n2_c     = sqe_c - fe_c;
		ma_c     = {a_q[F_W], a_q};
		ok1_c    = root_ok(n1_c, ma_c);
		ok2_c    = root_ok(n2_c, ma_c);
		dsh_c    = {drem_q[DR_W-2:0], 1'b0};
		pflat_c  = r1_q * bw_q;
		pv_c     = dq_q * bw_q;
	end

	assign crv_req.start = ((state_q == S_EDGE) && (bw_q != '0)) ||
		((state_q == S_CMIN) && crv_rsp.done);
	assign crv_req.curve = curve_q;
	assign crv_req.lam   = lam_c;

	cws_curve u_curve (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crv_req),
		.rsp    (crv_rsp)
	);

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			cmp_valid_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (cmd.opcode == OP_SAMPLE)) begin
						if (cmd.curve_select == CURVE_BAD) begin
							res_q  <= '{'0, '0, STAT_NOROOT};
							done_q <= 1'b1;
						end else begin
							curve_q      <= cmd.curve_select;
							r0_q         <= cmd.rand_band;
							r1_q         <= cmd.rand_within;
							n_q          <= n_eff;
							rd_idx_q     <= '0;
							cmp_valid_s1 <= 1'b0;
							state_q      <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// First entry above r0, or the last band in use.
					if (cmp_valid_s1 && ((rd_data_q > {1'b0, r0_q}) ||
						(cmp_idx_s1 == last_idx))) begin
						ib_q         <= cmp_idx_s1;
						cmp_valid_s1 <= 1'b0;
						state_q      <= S_EDGE;
					end else begin
						cmp_valid_s1 <= mem_re;
						cmp_idx_s1   <= rd_idx_q[BAND_W-1:0];
						if (mem_re) rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
				end
				S_EDGE: begin
					if (bw_q == '0) begin
						res_q   <= '{'0, 6'(ib_q), STAT_NOROOT};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lmin_q  <= lmin_c;
						state_q <= S_CMIN;
					end
				end
				S_CMIN: begin
					if (crv_rsp.done) begin
						fmin_q  <= fnew_c;
						state_q <= S_CMAX;
					end
				end
				S_CMAX: begin
					if (crv_rsp.done) begin
						a_q  <= a_c;
						s1_q <= mf1[31:0] * mf1[31:0];
						if (a_c == '0) begin
							if (fmin_q != '0) begin
								flat_q  <= 1'b1;
								state_q <= S_SCALE;
							end else begin
								res_q   <= '{'0, 6'(ib_q), STAT_NOROOT};
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end else begin
							flat_q  <= 1'b0;
							state_q <= S_SQ0;
						end
					end
				end
				S_SQ0: begin
					s0_q    <= mf0[31:0] * mf0[31:0];
					state_q <= S_SQ1;
				end
				S_SQ1: begin
					dneg_q  <= (s1_q < s0_q);
					state_q <= S_DP0;
				end
				S_DP0: begin
					dif_q   <= dneg_q ? (s0_q - s1_q) : (s1_q - s0_q);
					state_q <= S_DP1;
				end
				S_DP1: begin
					hi_q    <= dif_q[63:32] * r1_q;
					state_q <= S_DP2;
				end
				S_DP2: begin
					lo_q    <= dif_q[31:0] * r1_q;
					state_q <= S_DSC;
				end
				S_DSC: begin
					// A slightly negative discriminant is rounding noise and reads as zero.
					sres_q <= '0;
					sbit_q <= 64'd1 << 62;
					if (!dsc_c[64]) begin
						sx_q    <= dsc_c[63:0];
						state_q <= S_SQRT;
					end else if (dmag_c <= EPS_Q60) begin
						sx_q    <= '0;
						state_q <= S_SQRT;
					end else begin
						res_q   <= '{'0, 6'(ib_q), STAT_NOROOT};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SQRT: begin
					if (sx_q >= sres_q + sbit_q) begin
						sx_q   <= sx_q - (sres_q + sbit_q);
						sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
					if (sbit_q == 64'd1) state_q <= S_ROOT;
				end
				S_ROOT: begin
					// The root -fmin - sqrt is tried first, then -fmin + sqrt.
					dma_q  <= DR_W'(mag_num(ma_c));
					dq_q   <= '0;
					dcnt_q <= 5'd29;
					if (ok1_c) begin
						drem_q  <= DR_W'(mag_num(n1_c));
						state_q <= S_DIV;
					end else if (ok2_c) begin
						drem_q  <= DR_W'(mag_num(n2_c));
						state_q <= S_DIV;
					end else begin
						res_q   <= '{'0, 6'(ib_q), STAT_NOROOT};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (dsh_c >= dma_q) begin
						drem_q <= dsh_c - dma_q;
						dq_q   <= {dq_q[28:0], 1'b1};
					end else begin
						drem_q <= dsh_c;
						dq_q   <= {dq_q[28:0], 1'b0};
					end
					if (dcnt_q == '0) state_q <= S_SCALE;
					else dcnt_q <= dcnt_q - 5'd1;
				end
				S_SCALE: begin
					off_q   <= flat_q ? pflat_c[56:32] : pv_c[54:30];
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (|lam_fin[LAM_W-1:WL_W]) res_q.wavelength <= WL_MAX;
					else res_q.wavelength <= lam_fin[WL_W-1:0];
					res_q.band_index <= 6'(ib_q);
					res_q.status     <= STAT_OK;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign lam_fin = lmin_q + LAM_W'(off_q);

	assign done   = done_q;
	assign result = res_q;

	`include "assert_macros.svh"

	`ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a sample is still running")
	`ASSERT_NEXT(a_load_silent, accept && (cmd.opcode == OP_LOAD), !done,
		"a load produced a result")
	`ASSERT_NEXT(a_sample_busy,
		accept && (cmd.opcode == OP_SAMPLE) && (cmd.curve_select != CURVE_BAD), busy,
		"sample transfer did not start the sequencer")

endmodule

// ===== hdl/cws_curve.sv =====
// Serial evaluator of the piecewise-Gaussian color matching fit at one wavelength.
// Depends on cws_pkg for the lobe table, reciprocals and transfer structs.
module cws_curve import cws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  crv_req_t req,
	output crv_rsp_t rsp
);

	typedef enum logic [10:0] {
		C_IDLE = 11'b000_0000_0001,
		C_ARG  = 11'b000_0000_0010,
		C_TRND = 11'b000_0000_0100,
		C_XR   = 11'b000_0000_1000,
		C_KDIV = 11'b000_0001_0000,
		C_HMUL = 11'b000_0010_0000,
		C_HREC = 11'b000_0100_0000,
		C_HCOR = 11'b000_1000_0000,
		C_TERM = 11'b001_0000_0000,
		C_ACC  = 11'b010_0000_0000,
		C_DONE = 11'b100_0000_0000
	} cstate_t;

	cstate_t state_q;
	logic [1:0]       curve_q;
	logic [LAM_W-1:0] lam_q;
	logic [1:0]       li_q;
	logic [43:0]      dprod_q;
	logic             dbig_q;
	logic [39:0]      tt_q;
	logic [36:0]      x_q;
	logic [5:0]       k_q;
	logic [2:0]       j_q;
	logic [32:0]      acc_q;
	logic [3:0]       n_q;
	logic [64:0]      prod_q;
	logic [31:0]      p_q;
	logic [68:0]      m_q;
	logic [49:0]      wprod_q;
	logic signed [F_W-1:0] sum_q;

	lobe_t lb;
	logic [LAM_W-1:0] mu_e, d_c;
	logic [16:0]      s_c;
	logic [44:0]      trnd_c;
	logic [19:0]      t_c;
	logic [38:0]      x_c;
	logic [36:0]      ln2_sh;
	logic [32:0]      qest_c, q_c;
	logic [36:0]      qn_c, rem_c;
	logic [32:0]      e_c;
	logic [50:0]      wrnd_c;
	logic [F_W-1:0]   term_c;

	// Lobe distance, slope choice, rounding and the constant-reciprocal correction.
	always_comb begin
		lb     = lobe_get(curve_q, li_q);
		mu_e   = {{(LAM_W-26){1'b0}}, lb.mu};
		d_c    = (lam_q >= mu_e) ? (lam_q - mu_e) : (mu_e - lam_q);
		s_c    = (lam_q < mu_e) ? lb.s_below : lb.s_above;
		trnd_c = {1'b0, dprod_q} + 45'd524288;
		t_c    = trnd_c[39:20];
		x_c    = tt_q[39:1];
		ln2_sh = {5'b0, LN2_Q32} << j_q;
		qest_c = m_q[68:36];
		qn_c   = qest_c * n_q;
		rem_c  = {5'b0, p_q} - qn_c;
		q_c    = (rem_c >= {33'b0, n_q}) ? (qest_c + 33'd1) : qest_c;
		e_c    = acc_q >> k_q;
		wrnd_c = {1'b0, wprod_q} + 51'd131072;
		term_c = {1'b0, wrnd_c[50:18]};
	end

	// Sequencer: per nonzero-weight lobe of three, a range reduction and a nine-step Horner form.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			li_q    <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						curve_q <= req.curve;
						lam_q   <= req.lam;
						li_q    <= '0;
						sum_q   <= '0;
						state_q <= C_ARG;
					end
				end
				C_ARG: begin
					if (lb.w == '0) begin
						if (li_q == 2'd2) state_q <= C_DONE;
						else li_q <= li_q + 2'd1;
					end else begin
						dprod_q <= d_c[26:0] * s_c;
						dbig_q  <= |d_c[LAM_W-1:27];
						state_q <= C_TRND;
					end
				end
				C_TRND: begin
					if (dbig_q || (|trnd_c[44:40])) begin
						acc_q   <= '0;
						k_q     <= '0;
						state_q <= C_TERM;
					end else begin
						tt_q    <= t_c * t_c;
						state_q <= C_XR;
					end
				end
				C_XR: begin
					if (x_c >= X_LIM) begin
						acc_q   <= '0;
						k_q     <= '0;
						state_q <= C_TERM;
					end else begin
						x_q     <= x_c[36:0];
						k_q     <= '0;
						j_q     <= 3'd5;
						state_q <= C_KDIV;
					end
				end
				C_KDIV: begin
					if (x_q >= ln2_sh) begin
						x_q      <= x_q - ln2_sh;
						k_q[j_q] <= 1'b1;
					end
					if (j_q == 3'd0) begin
						acc_q   <= ONE_Q32;
						n_q     <= 4'd9;
						state_q <= C_HMUL;
					end else begin
						j_q <= j_q - 3'd1;
					end
				end
				C_HMUL: begin
					prod_q  <= x_q[31:0] * acc_q;
					state_q <= C_HREC;
				end
				C_HREC: begin
					p_q     <= prod_q[63:32];
					m_q     <= prod_q[63:32] * recip36(n_q);
					state_q <= C_HCOR;
				end
				C_HCOR: begin
					acc_q <= ONE_Q32 - q_c;
					if (n_q == 4'd1) state_q <= C_TERM;
					else begin
						n_q     <= n_q - 4'd1;
						state_q <= C_HMUL;
					end
				end
				C_TERM: begin
					wprod_q <= lb.w * e_c;
					state_q <= C_ACC;
				end
				C_ACC: begin
					sum_q <= lb.neg ? (sum_q - $signed(term_c)) : (sum_q + $signed(term_c));
					if (li_q == 2'd2) state_q <= C_DONE;
					else begin
						li_q    <= li_q + 2'd1;
						state_q <= C_ARG;
					end
				end
				C_DONE: begin
					// A new request may follow the response directly.
					if (req.start) begin
						curve_q <= req.curve;
						lam_q   <= req.lam;
						li_q    <= '0;
						sum_q   <= '0;
						state_q <= C_ARG;
					end else begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign rsp.done = (state_q == C_DONE);
	assign rsp.f    = sum_q;

endmodule

// ===== verif/cie_wavelength_sampler_test.sv =====
// Self-checking testbench of cie_wavelength_sampler: loads CDF tables, samples wavelengths
// and checks each result against a behavioral predictor of the block.
// Depends on cws_pkg and the RTL of cie_wavelength_sampler.
module cie_wavelength_sampler_test;
	import cws_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	res_t result;
	logic cfg_we;
	logic [1:0] cfg_addr;
	logic [WL_W-1:0] cfg_wdata;

	cie_wavelength_sampler u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy), .done(done),
		.result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// Predictor state: configuration and the three CDF tables.
	logic [WL_W-1:0] lo_wavelength;
	logic [BW_W-1:0] band_span;
	logic [BC_W-1:0] bands_used;
	logic [CDF_W-1:0] cdf_mem [0:MEM_DEPTH-1];

	cmd_t pend_q [$];
	res_t sample_q [$];
	int err_cnt;
	bit took;
	int gap_left;
	bit no_idle;

	// Lobes of the piecewise-Gaussian fit per curve: center, slopes, weight, sign.
	longint unsigned lobe_mu [0:2][0:2] = '{'{28966912, 39308493, 32840090},
		'{37276877, 34793062, 0}, '{28639232, 30081024, 0}};
	longint unsigned lobe_sb [0:2][0:2] = '{'{65431, 27682, 51380},
		'{22335, 64278, 0}, '{88605, 40370, 0}};
	longint unsigned lobe_sa [0:2][0:2] = '{'{39217, 33869, 40056},
		'{25900, 33764, 0}, '{29150, 76022, 0}};
	longint unsigned lobe_w [0:2][0:2] = '{'{23724, 69206, 4260},
		'{53805, 18743, 0}, '{79757, 44630, 0}};
	bit lobe_neg [0:2][0:2] = '{'{0, 0, 1}, '{0, 0, 0}, '{0, 0, 0}};

	// exp(-t^2/2) in Q.32 by range reduction and a Horner series.
	function automatic longint unsigned gauss(input longint unsigned t);
		longint unsigned x, k, r, acc, n;
		if (t >= (64'd1 << 20))
			return 0;
		x = (t * t) >> 1;
		k = x / 64'd2977044472;
		r = x - k * 64'd2977044472;
		acc = 64'd1 << 32;
		for (n = 9; n >= 1; n--)
			acc = (64'd1 << 32) - ((r * acc) >> 32) / n;
		if (k > 32)
			return 0;
		return acc >> k;
	endfunction

	// Curve value in Q.30 at a Q.16 wavelength.
	function automatic longint curve_val(input int c, input longint unsigned lam);
		longint sum, term;
		longint unsigned d, s, t;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			if (lobe_w[c][i] == 0)
				continue;
			d = (lam >= lobe_mu[c][i]) ? lam - lobe_mu[c][i] : lobe_mu[c][i] - lam;
			s = (lam < lobe_mu[c][i]) ? lobe_sb[c][i] : lobe_sa[c][i];
			t = (d * s + (64'd1 << 19)) >> 20;
			term = longint'((lobe_w[c][i] * gauss(t) + (64'd1 << 17)) >> 18);
			sum = lobe_neg[c][i] ? sum - term : sum + term;
		end
		return sum;
	endfunction

	function automatic longint unsigned mag(input longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > x)
			bt = bt >> 2;
		while (bt != 0) begin
			if (x >= res + bt) begin
				x = x - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// Root position in Q.30 when 0 <= num/a < 1.
	function automatic bit root_in_band(input longint num, input longint a,
			output longint unsigned v);
		longint unsigned mn, ma;
		mn = mag(num);
		ma = mag(a);
		v = 0;
		if (num != 0 && ((num > 0) != (a > 0)))
			return 0;
		if (mn >= ma)
			return 0;
		v = (mn << 30) / ma;
		return 1;
	endfunction

	// Expected result of one accepted command; returns 0 for a load.
	function automatic bit predict_sample(input cmd_t c, output res_t r);
		longint unsigned n, ib, lmin, off, lam, s0, s1, r1, v, pr;
		longint fmin, fmax, a, dsc, sq;
		bit ok;
		int cv;
		cv = c.curve_select;
		r = '{wavelength: '0, band_index: '0, status: STAT_NOROOT};
		if (c.opcode == OP_LOAD) begin
			if (c.curve_select != CURVE_BAD)
				cdf_mem[cv * MAX_BANDS + c.entry_index] = c.entry_value;
			return 0;
		end
		if (c.curve_select == CURVE_BAD)
			return 1;
		n = bands_used;
		if (n == 0)
			n = 1;
		if (n > MAX_BANDS)
			n = MAX_BANDS;
		for (ib = 0; ib < n; ib++)
			if (cdf_mem[cv * MAX_BANDS + ib] > {33'd0, c.rand_band})
				break;
		if (ib >= n)
			ib = n - 1;
		r.band_index = ib[5:0];
		if (band_span == 0)
			return 1;
		r1 = c.rand_within;
		lmin = longint'(lo_wavelength) + longint'(band_span) * ib;
		fmin = curve_val(cv, lmin);
		fmax = curve_val(cv, lmin + band_span);
		a = fmax - fmin;
		ok = 0;
		off = 0;
		if (a == 0) begin
			if (fmin != 0) begin
				off = (r1 * band_span) >> 32;
				ok = 1;
			end
		end else begin
			s0 = mag(fmin) * mag(fmin);
			s1 = mag(fmax) * mag(fmax);
			pr = (s1 >= s0) ? s1 - s0 : s0 - s1;
			pr = (pr >> 32) * r1 + (((pr & 64'hFFFF_FFFF) * r1) >> 32);
			dsc = (s1 >= s0) ? longint'(s0) + longint'(pr) : longint'(s0) - longint'(pr);
			if (dsc < 0 && dsc >= -64'sd1152921504607)
				dsc = 0;
			if (dsc >= 0) begin
				sq = longint'(floor_sqrt(dsc));
				if (root_in_band(-fmin - sq, a, v) || root_in_band(-fmin + sq, a, v)) begin
					off = (v * band_span) >> 30;
					ok = 1;
				end
			end
		end
		if (!ok)
			return 1;
		lam = lmin + off;
		if (lam > 64'd67108863)
			lam = 64'd67108863;
		r.wavelength = lam[WL_W-1:0];
		r.status = STAT_OK;
		return 1;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#60000000;
		$display("cie_wavelength_sampler_test: done, errors");
		$finish;
	end

	function automatic int pick_gap();
		int p;
		if (no_idle)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 250);
	endfunction

	// Driver: presents queued commands, holds each until its transfer, then may idle for a random gap.
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !took) begin
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pend_q.size() != 0) begin
				cmd <= pend_q.pop_front();
				start <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each result against the oldest expectation, then records
	// the expectation of a command transferred at this edge.
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && done === 1'b1) begin
			if (sample_q.size() == 0) begin
				$error("unexpected result %p", result);
				err_cnt++;
			end else begin
				exp_r = sample_q.pop_front();
				if (result.wavelength !== exp_r.wavelength) begin
					$error("wavelength: expected %0d, got %0d", exp_r.wavelength,
						result.wavelength);
					err_cnt++;
				end
				if (result.band_index !== exp_r.band_index) begin
					$error("band_index: expected %0d, got %0d", exp_r.band_index,
						result.band_index);
					err_cnt++;
				end
				if (result.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, result.status);
					err_cnt++;
				end
			end
		end
		took = arst_n && start && !busy;
		if (took && predict_sample(cmd, exp_r))
			sample_q.push_back(exp_r);
	end

	function automatic cmd_t make_load(input logic [1:0] c, input logic [5:0] idx,
			input logic [CDF_W-1:0] val);
		cmd_t m;
		m = '0;
		m.opcode = OP_LOAD;
		m.curve_select = c;
		m.entry_index = idx;
		m.entry_value = val;
		m.rand_band = $urandom();
		m.rand_within = $urandom();
		return m;
	endfunction

	function automatic cmd_t make_sample(input logic [1:0] c, input logic [31:0] r0,
			input logic [31:0] r1);
		cmd_t m;
		m = '0;
		m.opcode = OP_SAMPLE;
		m.curve_select = c;
		m.entry_index = 6'($urandom());
		m.entry_value = {1'($urandom_range(0, 1)), $urandom()};
		m.rand_band = r0;
		m.rand_within = r1;
		return m;
	endfunction

	// A monotone CDF with random steps for one curve, ending at or near one.
	task automatic queue_cdf(input logic [1:0] c);
		longint unsigned acc;
		acc = 0;
		for (int i = 0; i < MAX_BANDS; i++) begin
			acc += $urandom_range(0, 32'h0800_0000);
			if (acc > 64'h1_0000_0000 || i == MAX_BANDS - 1 && $urandom_range(0, 1))
				acc = 64'h1_0000_0000;
			pend_q.push_back(make_load(c, 6'(i), acc[CDF_W-1:0]));
		end
	endtask

	function automatic logic [31:0] pick_rand();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Waits for every transfer and result, then writes all three registers.
	task automatic set_config(input logic [WL_W-1:0] st, input logic [BW_W-1:0] bw,
			input logic [BC_W-1:0] bc);
		while (pend_q.size() != 0 || start || sample_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = REG_START;
		cfg_wdata = st;
		lo_wavelength = st;
		@(negedge clk);
		cfg_addr = REG_WIDTH;
		cfg_wdata = WL_W'(bw);
		band_span = bw;
		@(negedge clk);
		cfg_addr = REG_COUNT;
		cfg_wdata = WL_W'(bc);
		bands_used = bc;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Stimulus: full table load, directed cases, then random phases under
	// several configurations.
	initial begin
		logic [WL_W-1:0] st;
		logic [BW_W-1:0] bw;
		logic [BC_W-1:0] bc;
		int p;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_addr = REG_START;
		cfg_wdata = '0;
		err_cnt = 0;
		took = 0;
		gap_left = 0;
		no_idle = 0;
		lo_wavelength = START_RST;
		band_span = WIDTH_RST;
		bands_used = COUNT_RST;
		for (int i = 0; i < MEM_DEPTH; i++)
			cdf_mem[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every entry is written before any sample reads it.
		for (int c = 0; c < NUM_CURVES; c++)
			for (int i = 0; i < MAX_BANDS; i++)
				pend_q.push_back(make_load(2'(c), 6'(i), CDF_W'((33'd1 << 26) * (i + 1))));
		set_config(START_RST, WIDTH_RST, COUNT_RST);

		// Directed cases at the reset configuration.
		pend_q.push_back(make_load(CURVE_BAD, 6'd63, 33'h1_FFFF_FFFF));
		pend_q.push_back(make_sample(CURVE_BAD, 32'h8000_0000, 32'h8000_0000));
		for (int c = 0; c < NUM_CURVES; c++) begin
			pend_q.push_back(make_sample(2'(c), 32'd0, 32'd0));
			pend_q.push_back(make_sample(2'(c), 32'hFFFF_FFFF, 32'hFFFF_FFFF));
			pend_q.push_back(make_sample(2'(c), 32'h4000_0000, 32'h8000_0000));
			pend_q.push_back(make_sample(2'(c), 32'h2000_0000, 32'h0000_0001));
		end
		pend_q.push_back(make_load(2'd1, 6'd0, 33'h1_0000_0000));
		pend_q.push_back(make_sample(2'd1, 32'hFFFF_FFFF, 32'h1234_5678));
		pend_q.push_back(make_load(2'd0, 6'd5, 33'd0));
		pend_q.push_back(make_sample(2'd0, 32'd0, 32'hC000_0000));

		for (p = 0; p < 13; p++) begin
			case (p)
				0: begin st = '0; bw = 25'd1; bc = 7'd0; end
				1: begin st = WL_MAX; bw = 25'h1FF_FFFF; bc = 7'd127; end
				2: begin st = START_RST; bw = '0; bc = 7'd64; end
				3: begin st = '0; bw = 25'd26214400; bc = 7'd1; end
				4: begin st = 26'd23592960; bw = 25'd65536; bc = 7'd65; end
				default: begin
					st = WL_W'($urandom_range(20000000, 36000000));
					bw = BW_W'($urandom_range(1, 2000000));
					bc = ($urandom_range(0, 5) == 0) ? BC_W'($urandom_range(65, 127))
						: BC_W'($urandom_range(1, 64));
				end
			endcase
			set_config(st, bw, bc);
			no_idle = (p % 4 == 3);
			for (int k = 0; k < 30; k++) begin
				case ($urandom_range(0, 19))
					0: queue_cdf(2'($urandom_range(0, 2)));
					1, 2: pend_q.push_back(make_load(2'($urandom_range(0, 3)),
						6'($urandom()), {1'($urandom_range(0, 1)), $urandom()}));
					3: pend_q.push_back(make_sample(CURVE_BAD, $urandom(), $urandom()));
					default: pend_q.push_back(make_sample(2'($urandom_range(0, 2)),
						pick_rand(), pick_rand()));
				endcase
			end
		end
		set_config(START_RST, WIDTH_RST, COUNT_RST);

		if (err_cnt == 0) begin
			$display("cie_wavelength_sampler_test: done, clean");
		end else begin
			$display("cie_wavelength_sampler_test: done, errors");
		end
		$finish;
	end

endmodule
